@@ sv/dpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared constants and types of the polyline decimator.
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 20;
    localparam int TOL_BITS       = 16;
    localparam int INDEX_BITS     = 6;
    localparam int PDATA_W        = 32;
    localparam int PADDR_W        = 3;
    localparam int ADDR_LSB       = 2;
    localparam int CFG_IDX_W      = PADDR_W - ADDR_LSB;
    localparam int CMD_DEPTH      = 2;
    localparam int MUL_DIGIT      = 16;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_POP,
        S_POP_W,
        S_RD_A,
        S_RD_B,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_SC_RD,
        S_SC_D,
        S_SC_M1,
        S_SC_M2,
        S_SC_CMB,
        S_DEC,
        S_WM1,
        S_WM2,
        S_PUSH1,
        S_PUSH2,
        S_EMIT,
        S_EM_W,
        S_DONE
    } back_state_t;

endpackage

@@ sv/dpd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_in_if
// Point channel: one path point per transfer.
// ----------------------------------------------------------------------------
interface dpd_in_if #(
    parameter int COORD_BITS = dpd_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         in_last;

    modport source (output valid, output in_x, output in_y, output in_last, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_last, output ready);
endinterface

@@ sv/dpd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_out_if
// Kept point channel: one kept point per transfer.
// ----------------------------------------------------------------------------
interface dpd_out_if #(
    parameter int COORD_BITS = dpd_pkg::COORD_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      out_x;
    logic signed [COORD_BITS-1:0]      out_y;
    logic [dpd_pkg::INDEX_BITS-1:0]    out_index;
    logic                              out_last;

    modport source (output valid, output out_x, output out_y, output out_index,
                    output out_last, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_index,
                    input out_last, output ready);
endinterface

@@ sv/dpd_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_cmd_fifo
// Short queue of path jobs between the loader and the simplifier.
// ----------------------------------------------------------------------------
module dpd_cmd_fifo #(
    parameter int WIDTH = 7,
    parameter int DEPTH = dpd_pkg::CMD_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == NW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= din;
        end
    end
endmodule

@@ sv/dpd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_front
// Point loader: stores points, drops overflow, queues a job per path.
// ----------------------------------------------------------------------------
module dpd_front #(
    parameter int MAX_POINTS = dpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dpd_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dpd_in_if.sink                       point_ch,
    output logic                         wr_en,
    output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
    output logic signed [COORD_BITS-1:0] wr_x,
    output logic signed [COORD_BITS-1:0] wr_y,
    output logic                         cmd_push,
    output logic [$clog2(MAX_POINTS+1)-1:0] cmd_count,
    input  logic                         cmd_full,
    input  logic                         path_done
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          accept, store_full;

    assign point_ch.ready = !pend_reg && !cmd_full;
    assign accept         = point_ch.valid && point_ch.ready;
    assign store_full     = (count_reg == CW'(MAX_POINTS));
    assign wr_addr        = count_reg[AW-1:0];
    assign wr_x           = point_ch.in_x;
    assign wr_y           = point_ch.in_y;
    assign cmd_count      = count_reg + CW'(1);

    always_comb
    begin
        count_next = count_reg;
        pend_next  = pend_reg;
        wr_en      = 1'b0;
        cmd_push   = 1'b0;
        // a full store swallows the point and its last flag
        if (accept && !store_full)
        begin
            wr_en = 1'b1;
            if (point_ch.in_last)
            begin
                cmd_push   = 1'b1;
                count_next = '0;
                pend_next  = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (path_done)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end
endmodule

@@ sv/dpd_wide_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_wide_mul
// Multi-cycle unsigned multiplier, one 16-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module dpd_wide_mul #(
    parameter int W = 42
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output logic                done,
    output logic [W+((W+dpd_pkg::MUL_DIGIT-1)/dpd_pkg::MUL_DIGIT)*dpd_pkg::MUL_DIGIT-1:0] p
);
    localparam int DIG  = dpd_pkg::MUL_DIGIT;
    localparam int NDIG = (W + DIG - 1) / DIG;
    localparam int BW   = NDIG * DIG;
    localparam int PW   = W + BW;
    localparam int KW   = $clog2(NDIG + 1);

    logic [W-1:0]  a_reg;
    logic [BW-1:0] b_reg;
    logic [PW-1:0] acc_reg;
    logic [KW-1:0] cnt_reg;
    logic          run_reg, done_reg;
    logic [W+DIG-1:0] part;

    // most significant digit first, so the accumulator shifts left
    assign part = (W+DIG)'(a_reg) * (W+DIG)'(b_reg[BW-1 -: DIG]);
    assign done = done_reg;
    assign p    = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= KW'(NDIG);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BW'(b);
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            b_reg   <= b_reg << DIG;
            acc_reg <= (acc_reg << DIG) + PW'(part);
        end
    end
endmodule

@@ sv/dpd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_back
// Simplifier: point store, span stack, split search and kept-point output.
// ----------------------------------------------------------------------------
module dpd_back #(
    parameter int MAX_POINTS = dpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dpd_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dpd_pkg::TOL_BITS-1:0]  tol,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
    input  logic signed [COORD_BITS-1:0]  wr_x,
    input  logic signed [COORD_BITS-1:0]  wr_y,
    input  logic                          cmd_empty,
    input  logic [$clog2(MAX_POINTS+1)-1:0] cmd_count,
    output logic                          cmd_pop,
    output logic                          path_done,
    dpd_out_if.source                     keep_ch
);
    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;
    localparam int M    = 2 * D;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int TW   = 2 * dpd_pkg::TOL_BITS;
    localparam int W    = (M > TW) ? M : TW;
    localparam int DIG  = dpd_pkg::MUL_DIGIT;
    localparam int PW   = W + ((W + DIG - 1) / DIG) * DIG;

    // memories
    logic [2*C-1:0] pt_mem [MAX_POINTS];
    logic [2*AW-1:0] st_mem [MAX_POINTS];
    logic [2*C-1:0] rd_data_reg;
    logic [2*AW-1:0] st_rdata_reg;
    logic           rd_en, st_re, st_we;
    logic [AW-1:0]  rd_addr, st_raddr, st_waddr;
    logic [2*AW-1:0] st_wdata;

    dpd_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]  n_reg, n_next, sp_reg, sp_next, i_reg, i_next;
    logic           all_reg, all_next, found_reg, found_next;
    logic [TW-1:0]  tol2_reg, tol2_next;
    logic [AW-1:0]  lo_reg, lo_next, hi_reg, hi_next, bi_reg, bi_next;
    logic [M-1:0]   best_reg, best_next, len2_reg, len2_next;
    logic signed [C-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [D-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [D-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic signed [2*D-1:0] prod_reg, p1_reg, p1_next;
    logic signed [D-1:0] mul_a, mul_b;
    logic [MAX_POINTS-1:0] keep_reg, keep_next;
    logic [PW-1:0]  cross_reg, cross_next;

    logic signed [C-1:0] rx, ry;
    logic signed [2*D:0] s_add, s_sub, s_sel;
    logic [2*D:0]   s_abs;
    logic [M-1:0]   metric;
    logic           len0;
    logic [AW-1:0]  pop_lo, pop_hi;
    logic [CW-1:0]  nm1, i_inc;

    logic           wm_start, wm_done;
    logic [W-1:0]   wm_a, wm_b;
    logic [PW-1:0]  wm_p;

    logic           out_load, out_valid_reg;
    logic signed [C-1:0] ox_reg, oy_reg;
    logic [dpd_pkg::INDEX_BITS-1:0] oidx_reg;
    logic           olast_reg;

    dpd_wide_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wm_start),
        .a     (wm_a),
        .b     (wm_b),
        .done  (wm_done),
        .p     (wm_p)
    );

    assign rx     = rd_data_reg[2*C-1:C];
    assign ry     = rd_data_reg[C-1:0];
    assign len0   = (len2_reg == '0);
    assign pop_lo = st_rdata_reg[2*AW-1:AW];
    assign pop_hi = st_rdata_reg[AW-1:0];
    assign nm1    = n_reg - CW'(1);
    assign i_inc  = i_reg + CW'(1);

    // metric: squared distance on a degenerate span, else |cross|
    assign s_add  = {p1_reg[2*D-1], p1_reg} + {prod_reg[2*D-1], prod_reg};
    assign s_sub  = {p1_reg[2*D-1], p1_reg} - {prod_reg[2*D-1], prod_reg};
    assign s_sel  = len0 ? s_add : s_sub;
    assign s_abs  = s_sel[2*D] ? -s_sel : s_sel;
    assign metric = s_abs[M-1:0];

    assign keep_ch.valid     = out_valid_reg;
    assign keep_ch.out_x     = ox_reg;
    assign keep_ch.out_y     = oy_reg;
    assign keep_ch.out_index = oidx_reg;
    assign keep_ch.out_last  = olast_reg;

    always_comb
    begin
        unique case (state_reg)
            dpd_pkg::S_SQ2:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            dpd_pkg::S_SC_M1:
            begin
                mul_a = ex_reg;
                mul_b = len0 ? ex_reg : dy_reg;
            end
            dpd_pkg::S_SC_M2:
            begin
                mul_a = ey_reg;
                mul_b = len0 ? ey_reg : dx_reg;
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        sp_next    = sp_reg;
        i_next     = i_reg;
        all_next   = all_reg;
        found_next = found_reg;
        tol2_next  = tol2_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        bi_next    = bi_reg;
        best_next  = best_reg;
        len2_next  = len2_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        p1_next    = p1_reg;
        keep_next  = keep_reg;
        cross_next = cross_reg;
        rd_en      = 1'b0;
        rd_addr    = i_reg[AW-1:0];
        st_re      = 1'b0;
        st_raddr   = sp_reg[AW-1:0] - AW'(1);
        st_we      = 1'b0;
        st_waddr   = sp_reg[AW-1:0];
        st_wdata   = {lo_reg, bi_reg};
        wm_start   = 1'b0;
        wm_a       = W'(best_reg);
        wm_b       = W'(best_reg);
        cmd_pop    = 1'b0;
        path_done  = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            dpd_pkg::S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    n_next    = cmd_count;
                    tol2_next = TW'(tol) * TW'(tol);
                    i_next    = '0;
                    all_next  = (tol == '0) || (cmd_count < CW'(3));
                    if ((tol == '0) || (cmd_count < CW'(3)))
                    begin
                        state_next = dpd_pkg::S_EMIT;
                    end
                    else
                    begin
                        keep_next[0] = 1'b1;
                        keep_next[AW'(cmd_count - CW'(1))] = 1'b1;
                        st_we      = 1'b1;
                        st_waddr   = '0;
                        st_wdata   = {AW'(0), AW'(cmd_count - CW'(1))};
                        sp_next    = CW'(1);
                        state_next = dpd_pkg::S_POP;
                    end
                end
            end
            dpd_pkg::S_POP:
            begin
                if (sp_reg == '0)
                begin
                    i_next     = '0;
                    state_next = dpd_pkg::S_EMIT;
                end
                else
                begin
                    st_re      = 1'b1;
                    sp_next    = sp_reg - CW'(1);
                    state_next = dpd_pkg::S_POP_W;
                end
            end
            dpd_pkg::S_POP_W:
            begin
                lo_next = pop_lo;
                hi_next = pop_hi;
                if ((CW'(pop_hi) >= n_reg) || (CW'(pop_hi) <= CW'(pop_lo) + CW'(1)))
                begin
                    state_next = dpd_pkg::S_POP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pop_lo;
                    state_next = dpd_pkg::S_RD_A;
                end
            end
            dpd_pkg::S_RD_A:
            begin
                ax_next    = rx;
                ay_next    = ry;
                rd_en      = 1'b1;
                rd_addr    = hi_reg;
                state_next = dpd_pkg::S_RD_B;
            end
            dpd_pkg::S_RD_B:
            begin
                dx_next    = {rx[C-1], rx} - {ax_reg[C-1], ax_reg};
                dy_next    = {ry[C-1], ry} - {ay_reg[C-1], ay_reg};
                state_next = dpd_pkg::S_SQ1;
            end
            dpd_pkg::S_SQ1:
            begin
                state_next = dpd_pkg::S_SQ2;
            end
            dpd_pkg::S_SQ2:
            begin
                p1_next    = prod_reg;
                state_next = dpd_pkg::S_SQ3;
            end
            dpd_pkg::S_SQ3:
            begin
                len2_next  = s_add[M-1:0];
                found_next = 1'b0;
                best_next  = '0;
                bi_next    = lo_reg;
                i_next     = CW'(lo_reg) + CW'(1);
                state_next = dpd_pkg::S_SC_RD;
            end
            dpd_pkg::S_SC_RD:
            begin
                rd_en      = 1'b1;
                state_next = dpd_pkg::S_SC_D;
            end
            dpd_pkg::S_SC_D:
            begin
                ex_next    = {rx[C-1], rx} - {ax_reg[C-1], ax_reg};
                ey_next    = {ry[C-1], ry} - {ay_reg[C-1], ay_reg};
                state_next = dpd_pkg::S_SC_M1;
            end
            dpd_pkg::S_SC_M1:
            begin
                state_next = dpd_pkg::S_SC_M2;
            end
            dpd_pkg::S_SC_M2:
            begin
                p1_next    = prod_reg;
                state_next = dpd_pkg::S_SC_CMB;
            end
            dpd_pkg::S_SC_CMB:
            begin
                // strict compare keeps the earliest of equal metrics
                if (!found_reg || (metric > best_reg))
                begin
                    best_next  = metric;
                    bi_next    = i_reg[AW-1:0];
                    found_next = 1'b1;
                end
                i_next = i_inc;
                state_next = (i_inc == CW'(hi_reg)) ? dpd_pkg::S_DEC : dpd_pkg::S_SC_RD;
            end
            dpd_pkg::S_DEC:
            begin
                if (len0)
                begin
                    state_next = (W'(best_reg) > W'(tol2_reg)) ? dpd_pkg::S_PUSH1
                                                               : dpd_pkg::S_POP;
                end
                else
                begin
                    wm_start   = 1'b1;
                    state_next = dpd_pkg::S_WM1;
                end
            end
            dpd_pkg::S_WM1:
            begin
                if (wm_done)
                begin
                    cross_next = wm_p;
                    wm_start   = 1'b1;
                    wm_a       = W'(tol2_reg);
                    wm_b       = W'(len2_reg);
                    state_next = dpd_pkg::S_WM2;
                end
            end
            dpd_pkg::S_WM2:
            begin
                if (wm_done)
                begin
                    state_next = (cross_reg > wm_p) ? dpd_pkg::S_PUSH1 : dpd_pkg::S_POP;
                end
            end
            dpd_pkg::S_PUSH1:
            begin
                keep_next[bi_reg] = 1'b1;
                if ((CW'(bi_reg) > CW'(lo_reg) + CW'(1)) && (sp_reg < CW'(MAX_POINTS)))
                begin
                    st_we    = 1'b1;
                    st_wdata = {lo_reg, bi_reg};
                    sp_next  = sp_reg + CW'(1);
                end
                state_next = dpd_pkg::S_PUSH2;
            end
            dpd_pkg::S_PUSH2:
            begin
                if ((CW'(hi_reg) > CW'(bi_reg) + CW'(1)) && (sp_reg < CW'(MAX_POINTS)))
                begin
                    st_we    = 1'b1;
                    st_wdata = {bi_reg, hi_reg};
                    sp_next  = sp_reg + CW'(1);
                end
                state_next = dpd_pkg::S_POP;
            end
            dpd_pkg::S_EMIT:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = dpd_pkg::S_DONE;
                end
                else if (all_reg || keep_reg[i_reg[AW-1:0]])
                begin
                    rd_en      = 1'b1;
                    state_next = dpd_pkg::S_EM_W;
                end
                else
                begin
                    i_next = i_inc;
                end
            end
            dpd_pkg::S_EM_W:
            begin
                if (!out_valid_reg || keep_ch.ready)
                begin
                    out_load   = 1'b1;
                    i_next     = i_inc;
                    state_next = dpd_pkg::S_EMIT;
                end
            end
            dpd_pkg::S_DONE:
            begin
                keep_next  = '0;
                sp_next    = '0;
                path_done  = 1'b1;
                state_next = dpd_pkg::S_IDLE;
            end
            default:
            begin
                state_next = dpd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpd_pkg::S_IDLE;
            sp_reg        <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            keep_reg  <= keep_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (keep_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        all_reg   <= all_next;
        found_reg <= found_next;
        tol2_reg  <= tol2_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        bi_reg    <= bi_next;
        best_reg  <= best_next;
        len2_reg  <= len2_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        p1_reg    <= p1_next;
        prod_reg  <= M'(mul_a) * M'(mul_b);
        cross_reg <= cross_next;
        if (out_load)
        begin
            ox_reg    <= rx;
            oy_reg    <= ry;
            oidx_reg  <= dpd_pkg::INDEX_BITS'(i_reg);
            olast_reg <= (i_reg == nm1);
        end
    end

    // point store and span stack, registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pt_mem[wr_addr] <= {wr_x, wr_y};
        end
        if (rd_en)
        begin
            rd_data_reg <= pt_mem[rd_addr];
        end
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            st_rdata_reg <= st_mem[st_raddr];
        end
    end
endmodule

@@ sv/douglas_peucker_decimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// douglas_peucker_decimator
// Polyline simplifier: loads a path, runs Douglas-Peucker, emits kept points.
// ----------------------------------------------------------------------------
// Points stream in one per cycle and are stored until a transfer with in_last
// ends the path; the loader then stalls while the simplifier works. With a
// nonzero tolerance and three or more points, spans are taken from a stack:
// each span reads its end points and squares its length, then scans each
// interior point (one shared 21x21 multiplier does two products per point),
// and, for a non-degenerate span, runs two multi-cycle wide products for the
// exact squared compare. Output then walks the whole path, skipping dropped
// indices and sending each kept point, waiting while the sink is not ready.
// A zero tolerance or a path under three points passes every point. A point
// arriving with the store full is dropped along with its last flag. The
// tolerance register sits at byte address 0 and must be written while idle.
// ----------------------------------------------------------------------------
module douglas_peucker_decimator #(
    parameter int MAX_POINTS = dpd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dpd_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dpd_in_if.sink                       point_ch,
    dpd_out_if.source                    keep_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [dpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [dpd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [dpd_pkg::TOL_BITS-1:0]  tol_reg, tol_next;
    logic [dpd_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    // loader -> store write port
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic signed [COORD_BITS-1:0]  wr_x, wr_y;

    // job queue
    logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CW-1:0]                 cmd_in, cmd_out;
    logic                          path_done;

    // APB: zero wait states, index from the word address
    assign pready    = 1'b1;
    assign reg_idx   = paddr[dpd_pkg::PADDR_W-1:dpd_pkg::ADDR_LSB];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        tol_next = tol_reg;
        prdata   = '0;
        unique case (reg_idx)
            dpd_pkg::REG_TOLERANCE:
            begin
                prdata = dpd_pkg::PDATA_W'(tol_reg);
                if (cfg_write)
                begin
                    tol_next = pwdata[dpd_pkg::TOL_BITS-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    dpd_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .point_ch  (point_ch),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_x      (wr_x),
        .wr_y      (wr_y),
        .cmd_push  (cmd_push),
        .cmd_count (cmd_in),
        .cmd_full  (cmd_full),
        .path_done (path_done)
    );

    dpd_cmd_fifo #(
        .WIDTH (CW),
        .DEPTH (dpd_pkg::CMD_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    dpd_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_x      (wr_x),
        .wr_y      (wr_y),
        .cmd_empty (cmd_empty),
        .cmd_count (cmd_out),
        .cmd_pop   (cmd_pop),
        .path_done (path_done),
        .keep_ch   (keep_ch)
    );
endmodule
